[rtl/mlpd_pkg.sv]
// ============================================================================
// mlpd_pkg
// shared types and constants for the marker/length packet deframer
// ============================================================================
package mlpd_pkg;

    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 16;
    localparam int CRC_W     = 4;
    localparam int CFG_IDX_W = 2;

    // header layout
    localparam int HEADER_BYTES_DEF = 40;
    localparam int LENGTH_OFFSET    = 2;
    localparam int TAIL_OFFSET      = 38;

    // register reset values
    localparam logic [WORD_W-1:0] START_MARKER_RST = 16'hF0FE;
    localparam logic [WORD_W-1:0] TAIL_MARKER_RST  = 16'h0000;
    localparam logic [CRC_W-1:0]  CRC_TAIL_RST     = 4'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_MARKER = 2'd0,
        CFG_TAIL_MARKER  = 2'd1,
        CFG_CRC_TAIL     = 2'd2
    } cfg_idx_t;

    // per-bank push/pop request
    typedef struct packed {
        logic push;
        logic pop;
        logic wlast;
    } mlpd_bank_ctl_t;

    // fixed taps of one bank: queue head and the header fields
    typedef struct packed {
        logic [BYTE_W-1:0] hd_byte;
        logic              hd_last;
        logic [BYTE_W-1:0] w0;
        logic [BYTE_W-1:0] w1;
        logic [BYTE_W-1:0] w2;
        logic [BYTE_W-1:0] w3;
        logic [BYTE_W-1:0] t0;
        logic [BYTE_W-1:0] t1;
    } mlpd_taps_t;

    typedef struct packed {
        logic              hit;
        logic [WORD_W-1:0] rem;
    } mlpd_hdr_res_t;

endpackage

[rtl/mlpd_in_if.sv]
// ============================================================================
// mlpd_in_if
// raw byte channel into the deframer
// ============================================================================
interface mlpd_in_if;
    logic                        valid;
    logic                        ready;
    logic [mlpd_pkg::BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

[rtl/mlpd_out_if.sv]
// ============================================================================
// mlpd_out_if
// packet byte channel out of the deframer
// ============================================================================
interface mlpd_out_if;
    logic                        valid;
    logic                        ready;
    logic [mlpd_pkg::BYTE_W-1:0] packet_byte;
    logic                        packet_last;

    modport source (output valid, output packet_byte, output packet_last, input ready);
    modport sink   (input valid, input packet_byte, input packet_last, output ready);
endinterface

[rtl/mlpd_bank.sv]
// ============================================================================
// mlpd_bank
// byte shift line with fill count: header window while searching,
// output queue once a header is committed
// ============================================================================
module mlpd_bank #(
    parameter int  DEPTH  = 41,
    localparam int FILL_W = $clog2(DEPTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mlpd_pkg::mlpd_bank_ctl_t      ctl,
    input  logic [mlpd_pkg::BYTE_W-1:0]   wdata,
    output mlpd_pkg::mlpd_taps_t          taps,
    output logic [FILL_W-1:0]             fill
);
    import mlpd_pkg::*;

    logic [BYTE_W-1:0] byte_reg [DEPTH];
    logic              last_reg [DEPTH];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [FILL_W-1:0] wpos;

    // write slot moves down by one when the head leaves in the same cycle
    assign wpos = ctl.pop ? (fill_reg - FILL_W'(1)) : fill_reg;

    for (genvar i = 0; i < DEPTH; i++) begin : g_ent
        logic [BYTE_W-1:0] up_byte;
        logic              up_last;
        logic [BYTE_W-1:0] byte_next;
        logic              last_next;

        if (i < DEPTH - 1) begin : g_up
            assign up_byte = byte_reg[i + 1];
            assign up_last = last_reg[i + 1];
        end else begin : g_top
            assign up_byte = byte_reg[i];
            assign up_last = last_reg[i];
        end

        always_comb
        begin
            byte_next = byte_reg[i];
            last_next = last_reg[i];
            if (ctl.pop)
            begin
                byte_next = up_byte;
                last_next = up_last;
            end
            if (ctl.push && (wpos == FILL_W'(i)))
            begin
                byte_next = wdata;
                last_next = ctl.wlast;
            end
        end

        always_ff @(posedge clk)
        begin
            byte_reg[i] <= byte_next;
            last_reg[i] <= last_next;
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (ctl.push && !ctl.pop)
            fill_next = fill_reg + FILL_W'(1);
        else if (ctl.pop && !ctl.push)
            fill_next = fill_reg - FILL_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else
            fill_reg <= fill_next;
    end

    assign fill         = fill_reg;
    assign taps.hd_byte = byte_reg[0];
    assign taps.hd_last = last_reg[0];
    assign taps.w0      = byte_reg[0];
    assign taps.w1      = byte_reg[1];
    assign taps.w2      = byte_reg[LENGTH_OFFSET];
    assign taps.w3      = byte_reg[LENGTH_OFFSET + 1];
    assign taps.t0      = byte_reg[TAIL_OFFSET];
    assign taps.t1      = byte_reg[TAIL_OFFSET + 1];

endmodule

[rtl/mlpd_hdr_chk.sv]
// ============================================================================
// mlpd_hdr_chk
// header check on the window plus the byte that completes it
// ============================================================================
module mlpd_hdr_chk #(
    parameter int HEADER_BYTES = mlpd_pkg::HEADER_BYTES_DEF
) (
    input  mlpd_pkg::mlpd_taps_t              taps,
    input  logic [mlpd_pkg::BYTE_W-1:0]       newest,
    input  logic [mlpd_pkg::WORD_W-1:0]       start_marker,
    input  logic [mlpd_pkg::WORD_W-1:0]       tail_marker,
    input  logic [mlpd_pkg::CRC_W-1:0]        crc_tail_bytes,
    output mlpd_pkg::mlpd_hdr_res_t           res
);
    import mlpd_pkg::*;

    // the tail word's upper byte is the incoming one when it is the last header byte
    localparam bit TAIL_HI_NEW = (HEADER_BYTES - 1) == (TAIL_OFFSET + 1);

    logic [BYTE_W-1:0] tail_hi;
    logic [WORD_W-1:0] len;
    logic [WORD_W:0]   min_len;

    assign tail_hi = TAIL_HI_NEW ? newest : taps.t1;
    assign len     = {taps.w3, taps.w2};
    assign min_len = (WORD_W + 1)'(HEADER_BYTES) + (WORD_W + 1)'(crc_tail_bytes);

    assign res.hit = ({taps.w1, taps.w0} == start_marker) &&
                     ({tail_hi, taps.t0} == tail_marker) &&
                     ({1'b0, len} >= min_len);
    assign res.rem = len - WORD_W'(HEADER_BYTES);

endmodule

[rtl/marker_length_packet_deframer.sv]
// ============================================================================
// marker_length_packet_deframer
// sync marker / length prefixed deframer: finds a header in the byte
// stream, then forwards the header and the packet body with a last mark
// ============================================================================
//
//  port     dir   handshake        payload
//  -------  ----  ---------------  --------------------------------
//  byte_ch  sink  valid / ready    data_byte[7:0]
//  pkt_ch   src   valid / ready    packet_byte[7:0], packet_last
//  cfg      in    cfg_we           cfg_index[1:0], cfg_data[15:0]
//
//  one input word per cycle; the header check runs in the cycle the last
//  header byte arrives, against the window bank plus that byte
//  output words leave one per cycle from a registered stage, sink permitting
//  two banks of HEADER_BYTES+1 bytes: one drains a packet while the other
//  searches; input stalls while the search would start in a bank that has
//  not yet drained, or when the draining bank is full behind a stalled sink
//  reset clears control and registers only; bank contents need no clearing
//
module marker_length_packet_deframer #(
    parameter int HEADER_BYTES = mlpd_pkg::HEADER_BYTES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    mlpd_in_if.sink                            byte_ch,
    mlpd_out_if.source                         pkt_ch,
    input  logic                               cfg_we,
    input  logic [mlpd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mlpd_pkg::WORD_W-1:0]        cfg_data
);
    import mlpd_pkg::*;

    // one spare slot so a freshly committed bank still takes a body byte
    localparam int DEPTH  = HEADER_BYTES + 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    // config registers
    logic [WORD_W-1:0] start_marker_reg;
    logic [WORD_W-1:0] tail_marker_reg;
    logic [CRC_W-1:0]  crc_tail_reg;

    // control state
    logic              sel_reg, sel_next;           // bank taking input
    logic              drain_reg, drain_next;       // bank feeding the output
    logic              in_packet_reg, in_packet_next;
    logic [1:0]        commit_reg, commit_next;     // bank holds output words
    logic [WORD_W-1:0] rem_reg, rem_next;           // body bytes still to come

    // output stage
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;

    // bank wiring
    mlpd_bank_ctl_t    bank_ctl  [2];
    mlpd_taps_t        bank_taps [2];
    logic [FILL_W-1:0] bank_fill [2];

    mlpd_hdr_res_t     hdr_res;
    logic              acc;
    logic              in_ready;
    logic              search_full;
    logic              push;
    logic              drop;
    logic              wlast;
    logic              out_pop;
    logic [WORD_W-1:0] rem_dec;

    for (genvar k = 0; k < 2; k++) begin : g_bank
        mlpd_bank #(
            .DEPTH (DEPTH)
        ) u_bank (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (bank_ctl[k]),
            .wdata (byte_ch.data_byte),
            .taps  (bank_taps[k]),
            .fill  (bank_fill[k])
        );
    end

    mlpd_hdr_chk #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_hdr_chk (
        .taps           (bank_taps[sel_reg]),
        .newest         (byte_ch.data_byte),
        .start_marker   (start_marker_reg),
        .tail_marker    (tail_marker_reg),
        .crc_tail_bytes (crc_tail_reg),
        .res            (hdr_res)
    );

    // in a packet the bank only needs room; while searching it must be free
    assign in_ready    = in_packet_reg ? (bank_fill[sel_reg] != FILL_W'(DEPTH))
                                       : !commit_reg[sel_reg];
    assign byte_ch.ready = in_ready;
    assign acc         = byte_ch.valid && in_ready;
    assign search_full = bank_fill[sel_reg] == FILL_W'(HEADER_BYTES - 1);
    assign rem_dec     = rem_reg - WORD_W'(1);

    // head of the draining bank moves into the output stage when it is free
    assign out_pop = commit_reg[drain_reg] && (bank_fill[drain_reg] != '0) &&
                     (!out_valid_reg || pkt_ch.ready);

    always_comb
    begin
        sel_next       = sel_reg;
        drain_next     = drain_reg;
        in_packet_next = in_packet_reg;
        commit_next    = commit_reg;
        rem_next       = rem_reg;
        push           = 1'b0;
        drop           = 1'b0;
        wlast          = 1'b0;

        if (acc)
        begin
            push = 1'b1;
            if (in_packet_reg)
            begin
                // body byte queues behind the header
                rem_next = rem_dec;
                wlast    = (rem_dec == '0);
                if (rem_dec == '0)
                begin
                    in_packet_next = 1'b0;
                    sel_next       = ~sel_reg;
                end
            end
            else if (search_full)
            begin
                if (hdr_res.hit)
                begin
                    commit_next[sel_reg] = 1'b1;
                    rem_next             = hdr_res.rem;
                    // header-only packet ends on its last header byte
                    wlast                = (hdr_res.rem == '0);
                    if (hdr_res.rem == '0)
                        sel_next = ~sel_reg;
                    else
                        in_packet_next = 1'b1;
                end
                else
                begin
                    // slide the window by one byte
                    drop = 1'b1;
                end
            end
        end

        // drained bank goes back to the search pool
        if (commit_reg[drain_reg] && (bank_fill[drain_reg] == '0) &&
            !(in_packet_reg && (sel_reg == drain_reg)))
        begin
            commit_next[drain_reg] = 1'b0;
            drain_next             = ~drain_reg;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            bank_ctl[k].push  = push && (sel_reg == 1'(k));
            bank_ctl[k].pop   = (drop && (sel_reg == 1'(k))) ||
                                (out_pop && (drain_reg == 1'(k)));
            bank_ctl[k].wlast = wlast;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (out_pop)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = bank_taps[drain_reg].hd_byte;
            out_last_next  = bank_taps[drain_reg].hd_last;
        end
        else if (pkt_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg       <= 1'b0;
            drain_reg     <= 1'b0;
            in_packet_reg <= 1'b0;
            commit_reg    <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sel_reg       <= sel_next;
            drain_reg     <= drain_next;
            in_packet_reg <= in_packet_next;
            commit_reg    <= commit_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    // config writes, unknown index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= START_MARKER_RST;
            tail_marker_reg  <= TAIL_MARKER_RST;
            crc_tail_reg     <= CRC_TAIL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_START_MARKER: start_marker_reg <= cfg_data;
                CFG_TAIL_MARKER:  tail_marker_reg  <= cfg_data;
                CFG_CRC_TAIL:     crc_tail_reg     <= cfg_data[CRC_W-1:0];
                default:          ;
            endcase
        end
    end

    assign pkt_ch.valid       = out_valid_reg;
    assign pkt_ch.packet_byte = out_byte_reg;
    assign pkt_ch.packet_last = out_last_reg;

    // body bytes always land in a committed bank
    a_packet_bank_committed: assert property (@(posedge clk) disable iff (!rst_n)
        in_packet_reg |-> commit_reg[sel_reg])
        else $error("packet body targets an uncommitted bank");

    // a search window never reaches a full header without being resolved
    a_window_below_full: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_packet_reg && !commit_reg[sel_reg]) |->
            (bank_fill[sel_reg] < FILL_W'(HEADER_BYTES)))
        else $error("search window overfilled");

    a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        in_packet_reg |-> (rem_reg != '0))
        else $error("in packet with no body bytes left");

    // the oldest committed bank is always the one being drained
    a_drain_oldest: assert property (@(posedge clk) disable iff (!rst_n)
        !commit_reg[drain_reg] |-> !commit_reg[~drain_reg])
        else $error("committed bank not selected for draining");

endmodule

[verif/tb.sv]
// ============================================================================
// tb
// self-checking bench for the marker/length packet deframer: a queue-fed
// byte driver and a randomly stalling packet sink, with every packet word
// checked against a cycle-free model of the header search and body pass
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mlpd_pkg::*;

    localparam int HDR             = HEADER_BYTES_DEF;
    localparam int MAX_GAP         = 4;
    localparam int SETTLE_CYCLES   = 100;   // header burst drain plus margin
    localparam int PRESSURE_CYCLES = 600;   // long sink hold-off
    localparam int WATCHDOG_LIMIT  = 5000;  // cycles with no word moving
    localparam int MAX_REPORTS     = 10;
    localparam int FILL_RANDOM     = -1;

    // index with no register behind it, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] packet_byte;
        logic              packet_last;
    } pkt_word_t;

    // ------------------------------------------------------------------------
    // clock, reset, block under test
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_data;

    mlpd_in_if  byte_if ();
    mlpd_out_if pkt_if ();

    always #2 clk = ~clk;

    marker_length_packet_deframer #(
        .HEADER_BYTES (HDR)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ch   (byte_if),
        .pkt_ch    (pkt_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    logic [BYTE_W-1:0] link_bytes[$];      // bytes waiting to go onto the link
    pkt_word_t         expected_words[$];  // packet words the block still owes

    // model copy of the registers
    logic [WORD_W-1:0] start_marker_cfg;
    logic [WORD_W-1:0] tail_marker_cfg;
    logic [CRC_W-1:0]  crc_bytes_cfg;

    // model copy of the search / pass-through state
    logic [BYTE_W-1:0] search_win [HDR];
    int                win_count;
    bit                in_body;
    logic [WORD_W-1:0] body_left;

    // run control shared with the clocked processes
    bit no_idle;         // both sides run without gaps while set
    bit pressure_armed;  // asks the sink for one long hold-off
    bit pressure_done;

    int src_wait;
    int sink_wait;
    int hold_left;
    int stall_cycles;

    int unsigned fault_count;
    int unsigned bytes_in;
    int unsigned words_out;
    int unsigned headers_found;
    int unsigned windows_slid;
    int unsigned reg_writes;

    // ------------------------------------------------------------------------
    // header search model: one link byte in, zero or more packet words out
    // ------------------------------------------------------------------------
    function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
        pkt_word_t         w;
        logic [WORD_W-1:0] len_field;
        int                k;

        // body pass-through, one word per byte, last mark when the count runs out
        if (in_body) begin
            body_left = body_left - 1'b1;
            w.packet_byte = b;
            w.packet_last = (body_left == '0);
            expected_words.push_back(w);
            if (body_left == '0) begin
                in_body   = 1'b0;
                win_count = 0;
            end
            return;
        end

        if (win_count < HDR) begin
            search_win[win_count] = b;
            win_count++;
        end
        if (win_count < HDR)
            return;

        // full window: both markers little-endian, length must cover header and crc
        len_field = {search_win[LENGTH_OFFSET + 1], search_win[LENGTH_OFFSET]};
        if ({search_win[1], search_win[0]} == start_marker_cfg &&
            {search_win[TAIL_OFFSET + 1], search_win[TAIL_OFFSET]} == tail_marker_cfg &&
            int'(len_field) >= HDR + int'(crc_bytes_cfg)) begin
            body_left = len_field - WORD_W'(HDR);
            headers_found++;
            for (k = 0; k < HDR; k++) begin
                w.packet_byte = search_win[k];
                w.packet_last = (k == HDR - 1) && (body_left == '0);
                expected_words.push_back(w);
            end
            // header-only packet ends on its own last byte
            if (body_left == '0)
                win_count = 0;
            else
                in_body = 1'b1;
        end else begin
            // no header here, drop the oldest byte and keep looking
            for (k = 0; k < HDR - 1; k++)
                search_win[k] = search_win[k + 1];
            win_count = HDR - 1;
            windows_slid++;
        end
    endfunction

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // ------------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------------
    // one header with the given fields, then body_n random body bytes
    function automatic void push_frame(input logic [WORD_W-1:0] smark,
                                       input logic [WORD_W-1:0] len_field,
                                       input logic [WORD_W-1:0] tmark,
                                       input int body_n, input int fill);
        logic [BYTE_W-1:0] hb;
        int                k;

        for (k = 0; k < HDR; k++) begin
            if (k == 0)
                hb = smark[7:0];
            else if (k == 1)
                hb = smark[15:8];
            else if (k == LENGTH_OFFSET)
                hb = len_field[7:0];
            else if (k == LENGTH_OFFSET + 1)
                hb = len_field[15:8];
            else if (k == TAIL_OFFSET)
                hb = tmark[7:0];
            else if (k == TAIL_OFFSET + 1)
                hb = tmark[15:8];
            else
                hb = (fill < 0) ? BYTE_W'($urandom) : BYTE_W'(fill);
            link_bytes.push_back(hb);
        end
        repeat (body_n) link_bytes.push_back(BYTE_W'($urandom));
    endfunction

    // well-formed packet of total length len under the current registers
    function automatic void push_good(input int len);
        push_frame(start_marker_cfg, WORD_W'(len), tail_marker_cfg, len - HDR, FILL_RANDOM);
    endfunction

    // register write at a clock edge, model copy follows
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_START_MARKER: start_marker_cfg = val;
            CFG_TAIL_MARKER:  tail_marker_cfg  = val;
            CFG_CRC_TAIL:     crc_bytes_cfg    = val[CRC_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // all bytes taken and all words back, then let the block go quiet
    task automatic settle_phase();
        while (link_bytes.size() != 0 || expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // byte driver: presents the head of link_bytes, pops it once taken
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            byte_if.valid     <= 1'b0;
            byte_if.data_byte <= '0;
            src_wait = 0;
        end else begin
            if (byte_if.valid && byte_if.ready) begin
                deframe_byte(byte_if.data_byte);
                bytes_in++;
                void'(link_bytes.pop_front());
                src_wait = draw_gap();
            end
            if (byte_if.valid && !byte_if.ready) begin
                // word still on offer, hold it
            end else if (src_wait > 0 || link_bytes.size() == 0) begin
                byte_if.valid <= 1'b0;
                if (src_wait > 0)
                    src_wait--;
            end else begin
                byte_if.valid     <= 1'b1;
                byte_if.data_byte <= link_bytes[0];
            end
        end
    end

    // ------------------------------------------------------------------------
    // packet sink: random wait after each word, one long hold-off on request
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pkt_if.ready <= 1'b0;
            sink_wait = 0;
            hold_left = 0;
        end else begin
            if (pressure_armed && !pressure_done) begin
                pressure_done = 1'b1;
                hold_left     = PRESSURE_CYCLES;
            end
            if (pkt_if.valid && pkt_if.ready)
                sink_wait = draw_gap();
            if (hold_left > 0) begin
                hold_left--;
                pkt_if.ready <= 1'b0;
            end else if (sink_wait > 0) begin
                sink_wait--;
                pkt_if.ready <= 1'b0;
            end else begin
                pkt_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // word checker: every accepted word against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : check_words
        pkt_word_t want;
        if (rst_n && pkt_if.valid && pkt_if.ready) begin
            words_out++;
            if (expected_words.size() == 0) begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("%0t ns: unexpected word byte=%02h last=%0b", $time,
                             pkt_if.packet_byte, pkt_if.packet_last);
            end else begin
                want = expected_words.pop_front();
                if (pkt_if.packet_byte !== want.packet_byte ||
                    pkt_if.packet_last !== want.packet_last) begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                        $display("%0t ns: mismatch exp %02h/%0b got %02h/%0b",
                                 $time, want.packet_byte, want.packet_last,
                                 pkt_if.packet_byte, pkt_if.packet_last);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long with nothing moving on any port ends the run
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n || cfg_we || (byte_if.valid && byte_if.ready) ||
            (pkt_if.valid && pkt_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: nothing moved for %0d cycles, %0d words still owed",
                     stall_cycles, expected_words.size());
            $display("TEST FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        int extra;

        // known values on the register port from time zero
        cfg_we            = 1'b0;
        cfg_index         = CFG_START_MARKER;
        cfg_data          = '0;

        // model after reset
        start_marker_cfg = START_MARKER_RST;
        tail_marker_cfg  = TAIL_MARKER_RST;
        crc_bytes_cfg    = CRC_TAIL_RST;
        win_count        = 0;
        in_body          = 1'b0;
        body_left        = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed, reset registers -----------------------------------
        // stray bytes at both extremes, a header with a length one too short, then a real one
        link_bytes.push_back(8'h00);
        link_bytes.push_back(8'hFF);
        link_bytes.push_back(8'h00);
        push_frame(start_marker_cfg, WORD_W'(HDR + 1), tail_marker_cfg, 0, 8'hFF);
        push_good(HDR + 2);                  // shortest legal length
        settle_phase();

        // --- directed, zero crc, all-zero start and all-ones tail marker ----
        write_reg(CFG_UNMAPPED, 16'hFFFF);
        write_reg(CFG_START_MARKER, 16'h0000);
        write_reg(CFG_TAIL_MARKER, 16'hFFFF);
        write_reg(CFG_CRC_TAIL, 16'hFFF0);   // upper data bits are not part of the register
        no_idle = 1'b1;
        push_good(HDR);                      // header-only, back to back
        push_good(HDR);
        settle_phase();
        no_idle = 1'b0;

        // --- directed, largest crc count ---------------------------------
        write_reg(CFG_START_MARKER, 16'hFFFF);
        write_reg(CFG_TAIL_MARKER, 16'h0000);
        write_reg(CFG_CRC_TAIL, 16'h000F);
        push_good(HDR + 15);
        settle_phase();

        // --- random registers, sink goes away while bytes keep coming -------
        write_reg(CFG_START_MARKER, WORD_W'($urandom));
        write_reg(CFG_TAIL_MARKER, WORD_W'($urandom));
        write_reg(CFG_CRC_TAIL, WORD_W'($urandom));
        pressure_armed = 1'b1;
        // tail marker off by one bit, then a packet long enough to fill a bank
        push_frame(start_marker_cfg, WORD_W'(HDR + int'(crc_bytes_cfg)),
                   tail_marker_cfg ^ (16'h0001 << $urandom_range(0, 15)), 0, FILL_RANDOM);
        extra = $urandom_range(3, 7);
        push_good(HDR + int'(crc_bytes_cfg) + extra);
        settle_phase();

        $display("run: %0d link bytes, %0d packet words, %0d headers, %0d window slides",
                 bytes_in, words_out, headers_found, windows_slid);
        $display("covered %0d register writes, header-only packets and a %0d-cycle sink stall",
                 reg_writes, PRESSURE_CYCLES);
        if (fault_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
